// File: hdl/base64_stream_decoder_top_macros.svh
// assertion macros for the base64 stream decoder checker
// needs a clk and an active-low rst_n in the scope where they are used
`ifndef BASE64_STREAM_DECODER_TOP_MACROS_SVH
`define BASE64_STREAM_DECODER_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define B64D_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b64d checker: same-cycle rule broken");

// next-cycle implication, quiet during reset
`define B64D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b64d checker: next-cycle rule broken");

// next-cycle implication that also holds through reset
`define B64D_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("b64d checker: reset rule broken");

`endif

// File: hdl/b64d_pkg.sv
// shared types, constants and the alphabet lookup for the base64 decoder
// no dependencies
package b64d_pkg;

  localparam int BYTE_W    = 8;
  localparam int COUNT_W   = 16;
  localparam int SEXTET_W  = 6;
  localparam int ACC_W     = 24;
  localparam int GROUP_W   = 2;
  localparam int RES_SLOTS = 3;
  localparam int SLOT_W    = 2;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'hffff;

  // special characters of the alphabet
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2f;
  localparam logic [BYTE_W-1:0] CH_PAD   = 8'h3d;

  typedef struct packed {
    logic [ACC_W-1:0]   acc;
    logic [GROUP_W-1:0] group_cnt;
    logic [COUNT_W-1:0] out_cnt;
  } dec_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic               present;
    logic               done;
    logic [COUNT_W-1:0] count;
  } result_t;

  typedef result_t [RES_SLOTS-1:0] result_vec_t;

  // returns {kept, value}; kept is low for characters outside the alphabet
  function automatic logic [SEXTET_W:0] sextet_of(input logic [BYTE_W-1:0] ch);
    logic [SEXTET_W:0] r;
    r = '0;
    case (ch) inside
      [8'h41:8'h5a]: r = {1'b1, SEXTET_W'(ch - 8'h41)};   // upper case
      [8'h61:8'h7a]: r = {1'b1, SEXTET_W'(ch - 8'h47)};   // lower case, from 26
      [8'h30:8'h39]: r = {1'b1, SEXTET_W'(ch + 8'h04)};   // digits, from 52
      CH_PLUS:       r = {1'b1, 6'd62};
      CH_SLASH:      r = {1'b1, 6'd63};
      CH_PAD:        r = {1'b1, 6'd0};
      default:       r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/b64d_decode.sv
// one-character decode step: alphabet lookup, group assembly, limit and closing result
// depends on b64d_pkg
module b64d_decode (
  input  logic [b64d_pkg::BYTE_W-1:0]  in_char,
  input  logic                         first_char,
  input  logic                         last_char,
  input  logic [b64d_pkg::COUNT_W-1:0] limit,
  input  b64d_pkg::dec_state_t         st,
  output b64d_pkg::dec_state_t         st_nxt,
  output logic [b64d_pkg::SLOT_W-1:0]  n_res,
  output b64d_pkg::result_vec_t        res
);
  import b64d_pkg::*;

  dec_state_t          s0;
  logic [SEXTET_W:0]   sx;
  logic                kept;
  logic                full;
  logic [ACC_W-1:0]    acc1;
  logic [COUNT_W:0]    c_ext;
  logic [COUNT_W:0]    lim_ext;
  logic                emit1;
  logic                emit2;
  logic [SLOT_W-1:0]   m;

  always_comb begin
    s0 = first_char ? '0 : st;
    sx = sextet_of(in_char);
    kept = (s0.out_cnt < limit) && sx[SEXTET_W];
    acc1 = {s0.acc[ACC_W-SEXTET_W-1:0], sx[SEXTET_W-1:0]};
    full = kept && (s0.group_cnt == 2'd3);

    // bytes of a full group stop once the count meets the limit
    c_ext = {1'b0, s0.out_cnt};
    lim_ext = {1'b0, limit};
    emit1 = full && ((c_ext + 17'd1) < lim_ext);
    emit2 = full && ((c_ext + 17'd2) < lim_ext);
    m = SLOT_W'({1'b0, full} + {1'b0, emit1} + {1'b0, emit2});

    for (int k = 0; k < RES_SLOTS; k++) begin
      res[k].data    = acc1[ACC_W-1-BYTE_W*k -: BYTE_W];
      res[k].present = 1'b1;
      res[k].done    = 1'b0;
      res[k].count   = s0.out_cnt + COUNT_W'(k + 1);
    end

    n_res = m;
    if (last_char) begin
      case (m)
        2'd1:    res[0].done = 1'b1;
        2'd2:    res[1].done = 1'b1;
        2'd3:    res[2].done = 1'b1;
        default: begin
          // nothing decoded here: one closing word with the total
          res[0] = '{data: '0, present: 1'b0, done: 1'b1, count: s0.out_cnt};
          n_res  = 2'd1;
        end
      endcase
    end

    st_nxt.acc       = full ? '0 : (kept ? acc1 : s0.acc);
    st_nxt.group_cnt = full ? '0 : (kept ? s0.group_cnt + 2'd1 : s0.group_cnt);
    st_nxt.out_cnt   = s0.out_cnt + COUNT_W'(m);
  end

endmodule

// File: hdl/base64_stream_decoder_top.sv
// top level of the streaming base64 decoder: input register, decode step, result buffer
// depends on b64d_pkg and b64d_decode
// usage
//   input: in_valid/in_stall carry one character word a cycle; in_first_char opens a
//   message (clears group and byte count), in_last_char closes it
//   output: out_valid/out_stall carry one result word per decoded byte; the last word
//   of a message has out_message_done set and the total count
//   cfg_wr_en/cfg_wr_data set the byte limit per message; write only when idle
// timing
//   a character is registered at acceptance and decoded in the next cycle; its results
//   go into the result buffer as it advances; one character is taken every cycle unless
//   in_stall is up; a group-completing character puts up to three words in the buffer,
//   which drains one a cycle unless out_stall is up; a closing word right behind it holds
//   the input until the buffer is free, and characters with no result never wait
// reset
//   synchronous, active low: empties the input register and the result buffer,
//   clears group state and count, limit back to 65535
// stall
//   a stalled output holds its word; the input stalls once the held character
//   cannot move into the result buffer
module base64_stream_decoder_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // character input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [b64d_pkg::BYTE_W-1:0]  in_char,
  input  logic                         in_first_char,
  input  logic                         in_last_char,
  // decoded output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [b64d_pkg::BYTE_W-1:0]  out_byte,
  output logic                         out_byte_present,
  output logic                         out_message_done,
  output logic [b64d_pkg::COUNT_W-1:0] out_bytes_written,
  // limit register
  input  logic                         cfg_wr_en,
  input  logic [b64d_pkg::COUNT_W-1:0] cfg_wr_data
);
  import b64d_pkg::*;

  // input register
  logic                 in_vld_r;
  logic [BYTE_W-1:0]    char_r;
  logic                 first_r;
  logic                 last_r;

  // decode state and limit
  dec_state_t           st_r;
  dec_state_t           st_nxt;
  logic [COUNT_W-1:0]   limit_r;

  // result buffer, slot 0 drives the output
  result_vec_t          buf_r;
  result_vec_t          buf_nxt;
  logic [SLOT_W-1:0]    cnt_r;
  logic [SLOT_W-1:0]    cnt_nxt;

  result_vec_t          dec_res;
  logic [SLOT_W-1:0]    dec_n;

  logic                 in_acc;
  logic                 out_acc;
  logic                 room;
  logic                 adv;

  b64d_decode u_decode (
    .in_char    (char_r),
    .first_char (first_r),
    .last_char  (last_r),
    .limit      (limit_r),
    .st         (st_r),
    .st_nxt     (st_nxt),
    .n_res      (dec_n),
    .res        (dec_res)
  );

  assign out_valid = (cnt_r != '0);
  assign out_acc   = out_valid && !out_stall;
  // buffer is free for a new batch when empty or its last word leaves now
  assign room      = (cnt_r == '0) || ((cnt_r == 2'd1) && out_acc);
  // characters with no result never wait for the buffer
  assign adv       = in_vld_r && ((dec_n == '0) || room);
  assign in_stall  = in_vld_r && !adv;
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (adv && (dec_n != '0)) begin
      buf_nxt = dec_res;
      cnt_nxt = dec_n;
    end else if (out_acc) begin
      // shift the queue down one slot
      for (int k = 0; k < RES_SLOTS - 1; k++) begin
        buf_nxt[k] = buf_r[k+1];
      end
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      cnt_r    <= '0;
      st_r     <= '0;
      limit_r  <= LIMIT_RESET;
    end else begin
      if (in_acc) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      cnt_r <= cnt_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      char_r  <= in_char;
      first_r <= in_first_char;
      last_r  <= in_last_char;
    end
    buf_r <= buf_nxt;
  end

  assign out_byte          = buf_r[0].data;
  assign out_byte_present  = buf_r[0].present;
  assign out_message_done  = buf_r[0].done;
  assign out_bytes_written = buf_r[0].count;

endmodule

// File: hdl/b64d_checker.sv
// port-level checks for the base64 stream decoder, attached by bind
// depends on b64d_pkg and base64_stream_decoder_top_macros.svh
`include "base64_stream_decoder_top_macros.svh"

module b64d_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [b64d_pkg::BYTE_W-1:0]  out_byte,
  input logic                         out_byte_present,
  input logic                         out_message_done,
  input logic [b64d_pkg::COUNT_W-1:0] out_bytes_written
);
  import b64d_pkg::*;

  // a held word stays put
  `B64D_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_bytes_written) && $stable(out_message_done))

  // a word without a byte is only ever the closing word, with a zero byte
  `B64D_ASSERT_NOW(a_empty_closes, out_valid && !out_byte_present, out_message_done && (out_byte == '0))

  // a decoded byte always counts itself
  `B64D_ASSERT_NOW(a_byte_counted, out_valid && out_byte_present, out_bytes_written != '0)

  // reset empties the result buffer
  `B64D_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

  // reset empties the input register
  `B64D_ASSERT_RST(a_reset_no_stall, !rst_n, !in_stall)

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (.*);
